/* rtl/epf_pkg.sv */
// epf_pkg: shared widths, defaults and the controller/datapath bundles
// of the euler path finder
// no dependencies
package epf_pkg;

    // width of every vertex field on the ports
    localparam int VTX_W = 11;

    // default sizes
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 2048;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_step;     // zero one degree entry
        logic in_latch;     // capture the accepted request
        logic ld_edge;      // store edge, read degree of source
        logic ld_inc;       // bump source, read degree of target
        logic ld_dec;       // drop target
        logic tst_init;     // start degree test
        logic tst_rd;       // read degree of current vertex
        logic tst_chk;      // fold degree into test state
        logic walk_init;    // load start vertex on the stack
        logic scan_clr;     // restart edge scan
        logic scan_run;     // advance edge scan
        logic push;         // take the best edge
        logic pop;          // retire stack top to the path
        logic pop_load;     // new stack top from memory
        logic rp_clr;       // rewind path read pointer
        logic out_rd;       // read next path vertex
        logic out_path;     // present path vertex
        logic out_nopath;   // present no-path answer
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic func;
        logic edge_ok;
        logic tst_end;
        logic tst_fail;
        logic tst_ok;
        logic scan_done;
        logic can_push;
        logic depth_gt1;
        logic path_end;
        logic out_free;
        logic out_last;
    } t_sts;

endpackage

/* rtl/epf_ctrl.sv */
// epf_ctrl: sequencing state machine of the euler path finder
// depends on epf_pkg
module epf_ctrl import epf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_LD_A    = 4'd3;
    localparam logic [3:0] S_LD_B    = 4'd4;
    localparam logic [3:0] S_LD_C    = 4'd5;
    localparam logic [3:0] S_TST_RD  = 4'd6;
    localparam logic [3:0] S_TST_CHK = 4'd7;
    localparam logic [3:0] S_TST_END = 4'd8;
    localparam logic [3:0] S_WK_SCAN = 4'd9;
    localparam logic [3:0] S_WK_STEP = 4'd10;
    localparam logic [3:0] S_WK_POP  = 4'd11;
    localparam logic [3:0] S_OUT_RD  = 4'd12;
    localparam logic [3:0] S_OUT_WR  = 4'd13;
    localparam logic [3:0] S_NOPATH  = 4'd14;

    localparam logic [1:0] PH_LOAD = 2'd0;
    localparam logic [1:0] PH_READ = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;

    // input is taken only while waiting for work
    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.in_latch = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.func) begin
                    if (r_phase == PH_LOAD && i_sts.edge_ok) n_state = S_LD_A;
                    else n_state = S_IDLE;
                end else begin
                    unique case (r_phase)
                        PH_LOAD: begin
                            o_cmd.tst_init = 1'b1;
                            n_state = S_TST_RD;
                        end
                        PH_READ: n_state = S_OUT_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_A: begin
                o_cmd.ld_edge = 1'b1;
                n_state = S_LD_B;
            end
            S_LD_B: begin
                o_cmd.ld_inc = 1'b1;
                n_state = S_LD_C;
            end
            S_LD_C: begin
                o_cmd.ld_dec = 1'b1;
                n_state = S_IDLE;
            end
            S_TST_RD: begin
                if (i_sts.tst_end) n_state = S_TST_END;
                else begin
                    o_cmd.tst_rd = 1'b1;
                    n_state = S_TST_CHK;
                end
            end
            S_TST_CHK: begin
                o_cmd.tst_chk = 1'b1;
                if (i_sts.tst_fail) n_state = S_NOPATH;
                else n_state = S_TST_RD;
            end
            S_TST_END: begin
                if (i_sts.tst_ok) begin
                    o_cmd.walk_init = 1'b1;
                    o_cmd.scan_clr  = 1'b1;
                    n_state = S_WK_SCAN;
                end else begin
                    n_state = S_NOPATH;
                end
            end
            S_WK_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) n_state = S_WK_STEP;
            end
            S_WK_STEP: begin
                if (i_sts.can_push) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_WK_SCAN;
                end else begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.depth_gt1) n_state = S_WK_POP;
                    else begin
                        o_cmd.rp_clr = 1'b1;
                        n_phase = PH_READ;
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_WK_POP: begin
                o_cmd.pop_load = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state = S_WK_SCAN;
            end
            S_OUT_RD: begin
                if (i_sts.path_end) begin
                    n_phase = PH_DONE;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.out_rd = 1'b1;
                    n_state = S_OUT_WR;
                end
            end
            S_OUT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_path = 1'b1;
                    if (i_sts.out_last) n_phase = PH_DONE;
                    n_state = S_IDLE;
                end
            end
            S_NOPATH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_nopath = 1'b1;
                    n_phase = PH_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_phase <= PH_LOAD;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

/* rtl/epf_dp.sv */
// epf_dp: edge, degree, stack and path memories with the scan and
// output registers of the euler path finder
// depends on epf_pkg
module epf_dp import epf_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [VTX_W-1:0] i_cfg_data,
    input  logic             i_func,
    input  logic [VTX_W-1:0] i_edge_from,
    input  logic [VTX_W-1:0] i_edge_dest,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [VTX_W-1:0] o_vertex,
    output logic             o_no_path,
    output logic             o_last,
    input  t_cmd             i_cmd,
    output t_sts             o_sts
);

    localparam int VA  = $clog2(MAX_VERTICES + 1);
    localparam int EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC  = $clog2(MAX_EDGES + 1);
    localparam int PA  = $clog2(MAX_EDGES + 1);
    localparam int DW  = $clog2(MAX_EDGES + 2);
    localparam int DFW = $clog2(MAX_EDGES + 1) + 1;
    localparam int UW  = VTX_W + 1;
    localparam logic signed [DFW-1:0] ONE       = DFW'(1);
    localparam logic signed [DFW-1:0] MINUS_ONE = -ONE;

    // memories
    logic [VTX_W-1:0]         m_src  [MAX_EDGES];
    logic [VTX_W-1:0]         m_dst  [MAX_EDGES];
    logic                     m_used [MAX_EDGES];
    logic signed [DFW-1:0]    m_diff [MAX_VERTICES + 1];
    logic [VTX_W-1:0]         m_stk  [MAX_EDGES];
    logic [VTX_W-1:0]         m_path [MAX_EDGES + 1];

    logic [VTX_W-1:0]         r_vc;
    logic [VA-1:0]            r_clr;
    logic [EC-1:0]            r_loaded;
    logic                     r_func;
    logic [VTX_W-1:0]         r_from, r_dest;
    logic signed [DFW-1:0]    r_drd;
    logic [UW-1:0]            r_u;
    logic [VTX_W-1:0]         r_tsrc, r_tdst;
    logic                     r_bal;
    logic [EC-1:0]            r_sa, r_sidx;
    logic                     r_sv;
    logic [VTX_W-1:0]         r_src_rd, r_dst_rd;
    logic                     r_used_rd;
    logic                     r_found;
    logic [EC-1:0]            r_bidx;
    logic [VTX_W-1:0]         r_bdst;
    logic [VTX_W-1:0]         r_top;
    logic [DW-1:0]            r_depth, r_plen, r_rp;
    logic [VTX_W-1:0]         r_stk_rd, r_path_rd;
    logic                     r_o_valid;
    logic [VTX_W-1:0]         r_o_vtx;
    logic                     r_o_np, r_o_last;

    logic                     self_loop;
    logic                     scan_rd;
    logic                     hit;
    logic [VA-1:0]            d_raddr;

    assign self_loop = (r_from == r_dest);
    assign scan_rd   = i_cmd.scan_run && (r_sa < r_loaded);
    assign hit       = r_sv && !r_used_rd && (r_src_rd == r_top)
                       && (!r_found || r_dst_rd < r_bdst);

    // status
    assign o_sts.clr_done  = (r_clr == VA'(MAX_VERTICES));
    assign o_sts.func      = r_func;
    assign o_sts.edge_ok   = (32'(r_loaded) < MAX_EDGES) && (32'(r_from) <= MAX_VERTICES)
                             && (32'(r_dest) <= MAX_VERTICES);
    assign o_sts.tst_end   = (32'(r_u) > 32'(r_vc)) || (32'(r_u) > MAX_VERTICES);
    assign o_sts.tst_fail  = !((r_drd == '0) || (r_drd == ONE && r_tsrc == '0)
                             || (r_drd == MINUS_ONE && r_tdst == '0));
    assign o_sts.tst_ok    = r_bal || (r_tsrc != '0 && r_tdst != '0);
    assign o_sts.scan_done = !(r_sa < r_loaded) && !r_sv;
    assign o_sts.can_push  = r_found && (32'(r_depth) <= MAX_EDGES);
    assign o_sts.depth_gt1 = (r_depth > DW'(1));
    assign o_sts.path_end  = (r_rp >= r_plen);
    assign o_sts.out_free  = !r_o_valid || !i_stall;
    assign o_sts.out_last  = (DW'(r_rp + DW'(1)) >= r_plen);

    assign o_valid   = r_o_valid;
    assign o_vertex  = r_o_vtx;
    assign o_no_path = r_o_np;
    assign o_last    = r_o_last;

    // degree memory read address
    always_comb begin
        d_raddr = '0;
        if (i_cmd.ld_edge) d_raddr = VA'(r_from);
        else if (i_cmd.ld_inc) d_raddr = VA'(r_dest);
        else if (i_cmd.tst_rd) d_raddr = VA'(r_u);
    end

    // degree balance memory: out minus in per vertex
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) m_diff[r_clr] <= '0;
        else if (i_cmd.ld_inc && !self_loop) m_diff[VA'(r_from)] <= r_drd + ONE;
        else if (i_cmd.ld_dec && !self_loop) m_diff[VA'(r_dest)] <= r_drd - ONE;
        r_drd <= m_diff[d_raddr];
    end

    // edge memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_edge) begin
            m_src[EA'(r_loaded)] <= r_from;
            m_dst[EA'(r_loaded)] <= r_dest;
        end
        if (scan_rd) begin
            r_src_rd <= m_src[r_sa[EA-1:0]];
            r_dst_rd <= m_dst[r_sa[EA-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_edge) m_used[EA'(r_loaded)] <= 1'b0;
        else if (i_cmd.push) m_used[r_bidx[EA-1:0]] <= 1'b1;
        if (scan_rd) r_used_rd <= m_used[r_sa[EA-1:0]];
    end

    // walk stack below the top register
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) m_stk[EA'(r_depth - DW'(1))] <= r_top;
        if (i_cmd.pop) r_stk_rd <= m_stk[EA'(r_depth - DW'(2))];
    end

    // finished path, read back in reverse
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop && 32'(r_plen) <= MAX_EDGES) m_path[PA'(r_plen)] <= r_top;
        if (i_cmd.out_rd) r_path_rd <= m_path[PA'(r_plen - DW'(1) - r_rp)];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc      <= VTX_W'(1);
            r_clr     <= '0;
            r_loaded  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_vc <= i_cfg_data;
            if (i_cmd.clr_step && !o_sts.clr_done) r_clr <= r_clr + VA'(1);
            if (i_cmd.ld_edge) r_loaded <= r_loaded + EC'(1);
            if (i_cmd.out_path || i_cmd.out_nopath) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    // request, degree test, walk and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_latch) begin
            r_func <= i_func;
            r_from <= i_edge_from;
            r_dest <= i_edge_dest;
        end
        if (i_cmd.tst_init) begin
            r_u    <= UW'(1);
            r_tsrc <= '0;
            r_tdst <= '0;
            r_bal  <= 1'b1;
        end else if (i_cmd.tst_chk) begin
            r_u <= r_u + UW'(1);
            if (r_drd != '0) begin
                r_bal <= 1'b0;
                if (r_drd == ONE && r_tsrc == '0) r_tsrc <= r_u[VTX_W-1:0];
                else if (r_drd == MINUS_ONE && r_tdst == '0) r_tdst <= r_u[VTX_W-1:0];
            end
        end
        // edge scan for the smallest unused target
        if (i_cmd.scan_clr) begin
            r_sa    <= '0;
            r_sv    <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_sv <= scan_rd;
            if (scan_rd) begin
                r_sa   <= r_sa + EC'(1);
                r_sidx <= r_sa;
            end
            if (hit) begin
                r_found <= 1'b1;
                r_bidx  <= r_sidx;
                r_bdst  <= r_dst_rd;
            end
        end
        // stack top and counts
        if (i_cmd.walk_init) begin
            r_top   <= r_bal ? VTX_W'(1) : r_tsrc;
            r_depth <= DW'(1);
            r_plen  <= '0;
        end else if (i_cmd.push) begin
            r_top   <= r_bdst;
            r_depth <= r_depth + DW'(1);
        end else if (i_cmd.pop) begin
            r_depth <= r_depth - DW'(1);
            r_plen  <= r_plen + DW'(1);
        end else if (i_cmd.pop_load) begin
            r_top <= r_stk_rd;
        end
        if (i_cmd.rp_clr) r_rp <= '0;
        else if (i_cmd.out_path) r_rp <= r_rp + DW'(1);
        if (i_cmd.out_path) begin
            r_o_vtx  <= r_path_rd;
            r_o_np   <= 1'b0;
            r_o_last <= o_sts.out_last;
        end else if (i_cmd.out_nopath) begin
            r_o_vtx  <= '0;
            r_o_np   <= 1'b1;
            r_o_last <= 1'b1;
        end
    end

endmodule

/* rtl/euler_path_finder.sv */
// euler_path_finder: top level, joins controller and datapath
// depends on epf_pkg, epf_ctrl, epf_dp
//
// Usage: set vertex_count on the config channel (valid/ready, always
// ready) while idle, then send requests with func 0 to load directed
// edges and func 1 to fetch the path one vertex at a time.
// Input channel: i_valid with o_stall; a request is taken when i_valid
// is high and o_stall low. Output channel: o_valid with i_stall.
// After reset the degree memory is cleared, one vertex entry a cycle;
// o_stall stays high until every entry is zero.
// Edge load: a request is taken, decoded, then makes three degree-memory
// accesses through its one read and one write port; no result.
// First fetch: a degree test reads and checks each vertex in turn, then
// the walk scans all loaded edges once per walk step. Later fetches
// read the next vertex back from the path memory.
// A result sits in the output register; while i_stall is high it holds
// and a request that needs to emit waits in its final state.
// Fetches after the last vertex or the no-path answer give no result.
module euler_path_finder import epf_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [VTX_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_func,
    input  logic [VTX_W-1:0] i_edge_from,
    input  logic [VTX_W-1:0] i_edge_dest,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [VTX_W-1:0] o_vertex,
    output logic             o_no_path,
    output logic             o_last
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    epf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // storage and arithmetic
    epf_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_edge_from (i_edge_from),
        .i_edge_dest (i_edge_dest),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_vertex    (o_vertex),
        .o_no_path   (o_no_path),
        .o_last      (o_last),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

/* test/tb_euler_path_finder.sv */
// tb_euler_path_finder: loads a random trail of directed edges plus ignored
// edges, then fetches the whole path and checks every vertex against a predictor
// depends on epf_pkg and euler_path_finder
module tb_euler_path_finder;
    import epf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int NE = DEF_MAX_EDGES;
    localparam int TRAIL_EDGES = 440;

    typedef enum logic [1:0] {WALK_LOAD, WALK_READ, WALK_DONE} t_walk_phase;

    typedef struct {
        logic [VTX_W-1:0] vertex;
        logic             no_path;
        logic             last;
    } t_path_step;

    typedef struct {
        logic             func;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
    } t_req;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [VTX_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    logic             i_func;
    logic [VTX_W-1:0] i_edge_from;
    logic [VTX_W-1:0] i_edge_dest;
    logic             o_valid;
    logic             i_stall;
    logic [VTX_W-1:0] o_vertex;
    logic             o_no_path;
    logic             o_last;

    euler_path_finder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_edge_from (i_edge_from),
        .i_edge_dest (i_edge_dest),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_vertex    (o_vertex),
        .o_no_path   (o_no_path),
        .o_last      (o_last)
    );

    // predictor state
    int unsigned      vtx_count;
    logic [VTX_W-1:0] edge_src [NE];
    logic [VTX_W-1:0] edge_dst [NE];
    bit               edge_taken [NE];
    int               deg_in [NV+1];
    int               deg_out [NV+1];
    int               edge_total;
    logic [VTX_W-1:0] path_rev [$];
    int               read_idx;
    t_walk_phase      walk_phase;

    t_path_step       path_q [$];
    int               errors;
    bit               quiet;

    // directed requests: extremes, ignored endpoints, tied destinations, vertex zero
    t_req directed_reqs [] = '{
        '{1'b0, 11'd2047, 11'd5},
        '{1'b0, 11'd5,    11'd1025},
        '{1'b0, 11'd1025, 11'd2047},
        '{1'b0, 11'd1,    11'd1024},
        '{1'b0, 11'd1024, 11'd1},
        '{1'b0, 11'd1,    11'd1024},
        '{1'b0, 11'd1024, 11'd0},
        '{1'b0, 11'd0,    11'd1},
        '{1'b0, 11'd1536, 11'd1024}
    };

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // degree test: start vertex, or zero when no path exists
    function automatic int degree_start();
        int n;
        int diff;
        int from_v;
        int to_v;
        bit flat;
        n = (vtx_count > NV) ? NV : vtx_count;
        flat = 1;
        from_v = 0;
        to_v = 0;
        for (int u = 1; u <= n; u++) begin
            diff = deg_out[u] - deg_in[u];
            if (diff != 0) begin
                flat = 0;
                if (diff == 1 && from_v == 0) begin
                    from_v = u;
                end else if (diff == -1 && to_v == 0) begin
                    to_v = u;
                end else begin
                    from_v = 0;
                    to_v = 0;
                    break;
                end
            end
        end
        if (flat) return 1;
        if (from_v != 0 && to_v != 0) return from_v;
        return 0;
    endfunction

    // hierholzer walk, smallest destination first, earliest edge on ties
    function automatic void hierholzer(int start);
        logic [VTX_W-1:0] stk [$];
        logic [VTX_W-1:0] u;
        int best;
        stk.insert(stk.size(), VTX_W'(start));
        path_rev.delete();
        while (stk.size() > 0) begin
            u = stk[$];
            best = -1;
            for (int e = 0; e < edge_total; e++) begin
                if (!edge_taken[e] && edge_src[e] == u &&
                    (best < 0 || edge_dst[e] < edge_dst[best]))
                    best = e;
            end
            if (best >= 0 && stk.size() <= NE) begin
                edge_taken[best] = 1;
                stk.insert(stk.size(), edge_dst[best]);
            end else begin
                if (path_rev.size() <= NE) path_rev.insert(path_rev.size(), u);
                void'(stk.pop_back());
            end
        end
    endfunction

    // apply one accepted request to the predictor
    function automatic void predict_request(t_req r);
        t_path_step s;
        int start;
        if (r.func == 1'b0) begin
            if (walk_phase != WALK_LOAD || edge_total >= NE) return;
            if (r.src > NV || r.dst > NV) return;
            edge_src[edge_total] = r.src;
            edge_dst[edge_total] = r.dst;
            edge_taken[edge_total] = 0;
            deg_out[r.src]++;
            deg_in[r.dst]++;
            edge_total++;
            return;
        end
        if (walk_phase == WALK_DONE) return;
        if (walk_phase == WALK_LOAD) begin
            start = degree_start();
            if (start == 0) begin
                walk_phase = WALK_DONE;
                s = '{'0, 1'b1, 1'b1};
                path_q.insert(path_q.size(), s);
                return;
            end
            hierholzer(start);
            read_idx = 0;
            walk_phase = WALK_READ;
        end
        if (read_idx >= path_rev.size()) begin
            walk_phase = WALK_DONE;
            return;
        end
        s.vertex = path_rev[path_rev.size() - 1 - read_idx];
        s.no_path = 1'b0;
        read_idx++;
        s.last = (read_idx >= path_rev.size());
        if (s.last) walk_phase = WALK_DONE;
        path_q.insert(path_q.size(), s);
    endfunction

    // send one request with random gaps in front
    task automatic send_request(t_req r);
        while (!quiet && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= r.func;
        i_edge_from <= r.src;
        i_edge_dest <= r.dst;
        do @(posedge i_clk); while (o_stall);
        predict_request(r);
    endtask

    // write vertex_count while the block is idle
    task automatic write_vertex_count(logic [VTX_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        vtx_count = v;
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 35);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_path_step s;
        if (i_rst_n && o_valid && !i_stall) begin
            if (path_q.size() == 0) begin
                $error("unexpected result: vertex %0d no_path %0d last %0d",
                       o_vertex, o_no_path, o_last);
                errors++;
            end else begin
                s = path_q.pop_front();
                if (o_vertex !== s.vertex) begin
                    $error("vertex: expected %0d, got %0d", s.vertex, o_vertex);
                    errors++;
                end
                if (o_no_path !== s.no_path) begin
                    $error("no_path: expected %0d, got %0d", s.no_path, o_no_path);
                    errors++;
                end
                if (o_last !== s.last) begin
                    $error("last: expected %0d, got %0d", s.last, o_last);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

    // main sequence
    initial begin
        t_req trail [$];
        t_req r;
        t_req tmp;
        logic [VTX_W-1:0] cur;
        logic [VTX_W-1:0] nxt;
        logic [VTX_W-1:0] first_v;
        int j;
        int fetches;

        errors = 0;
        quiet = 0;
        vtx_count = 1;
        edge_total = 0;
        read_idx = 0;
        walk_phase = WALK_LOAD;
        foreach (deg_in[k]) begin
            deg_in[k] = 0;
            deg_out[k] = 0;
        end
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_func      <= 1'b0;
        i_edge_from <= '0;
        i_edge_dest <= '0;
        i_stall     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_vertex_count(11'd1);

        // directed part
        foreach (directed_reqs[k]) send_request(directed_reqs[k]);
        @(posedge i_clk);
        i_valid <= 1'b0;
        repeat (20) @(posedge i_clk);
        write_vertex_count(11'd2047);
        write_vertex_count(11'd0);

        // random open trail between two distinct vertices, shuffled
        first_v = $urandom_range(1, 40);
        cur = first_v;
        for (int k = 0; k < TRAIL_EDGES; k++) begin
            if ($urandom_range(9) == 0)
                nxt = $urandom_range(1) ? 11'd0 : 11'd1024;
            else
                nxt = $urandom_range(1, 40);
            if (k == TRAIL_EDGES - 1 && (nxt == first_v || nxt == 0 || nxt == 1024))
                nxt = (first_v == 40) ? 11'd1 : first_v + 1;
            tmp = '{1'b0, cur, nxt};
            trail.insert(trail.size(), tmp);
            cur = nxt;
        end
        for (int k = trail.size() - 1; k > 0; k--) begin
            j = $urandom_range(k);
            tmp = trail[k];
            trail[k] = trail[j];
            trail[j] = tmp;
        end

        // load the trail with ignored edges mixed in
        foreach (trail[k]) begin
            if (k == trail.size() / 2) begin
                @(posedge i_clk);
                i_valid <= 1'b0;
                repeat (20) @(posedge i_clk);
                write_vertex_count(11'd1024);
            end
            quiet = (k >= 150 && k < 250);
            if ($urandom_range(9) == 0) begin
                r.func = 1'b0;
                r.src = $urandom_range(1) ? $urandom_range(1025, 2047) : $urandom_range(0, 40);
                r.dst = (r.src > NV) ? $urandom_range(0, 2047) : $urandom_range(1025, 2047);
                send_request(r);
            end
            send_request(trail[k]);
        end

        // fetch the whole path and a few more
        fetches = TRAIL_EDGES + 10;
        for (int k = 0; k < fetches; k++) begin
            r.func = 1'b1;
            r.src = $urandom_range(0, 2047);
            r.dst = $urandom_range(0, 2047);
            send_request(r);
            if (k == 100) begin
                @(posedge i_clk);
                i_valid <= 1'b0;
                while (path_q.size() != 0) @(posedge i_clk);
            end
        end
        @(posedge i_clk);
        i_valid <= 1'b0;

        while (path_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
